// File: design/ustbl_pkg.sv
// ----------------------------------------------------------------------------
// ustbl_pkg
// Shared types and constants for the unordered integer set table.
// ----------------------------------------------------------------------------
package ustbl_pkg;

    localparam int unsigned SET_DEPTH_DEF = 32;
    localparam int unsigned KEY_W         = 32;
    localparam int unsigned OP_W          = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_LOOKUP = 2'd2
    } ustbl_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMMIT
    } ustbl_state_t;

    // search token walking down the cell chain
    typedef struct packed {
        logic tok;
        logic found;
    } ustbl_probe_t;

    // write strobes broadcast to all cells at commit time
    typedef struct packed {
        logic load;
        logic shift;
    } ustbl_commit_t;

endpackage

// File: design/ustbl_cell.sv
// ----------------------------------------------------------------------------
// ustbl_cell
// One store slot: holds a key, compares it when the search token passes and
// hands the token on. On erase, slots at and after the hit take the key of
// their right neighbor.
// ----------------------------------------------------------------------------
module ustbl_cell
    import ustbl_pkg::*;
#(
    parameter int unsigned SET_DEPTH = SET_DEPTH_DEF,
    parameter int unsigned IDX       = 0
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  ustbl_probe_t                       probe_in,
    output ustbl_probe_t                       probe_out,
    input  logic signed [KEY_W-1:0]            search_key,
    input  logic [$clog2(SET_DEPTH+1)-1:0]     count,
    input  ustbl_commit_t                      commit,
    input  logic signed [KEY_W-1:0]            key_right,
    output logic signed [KEY_W-1:0]            key_out
);

    localparam int unsigned CW = $clog2(SET_DEPTH + 1);
    localparam logic [CW-1:0] SLOT = CW'(IDX);

    logic signed [KEY_W-1:0] key_reg;
    logic                    shift_reg;
    ustbl_probe_t            probe_reg;
    logic                    match;

    assign match = probe_in.tok && (SLOT < count) && (key_reg == search_key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
            shift_reg <= 1'b0;
        end
        else
        begin
            probe_reg.tok   <= probe_in.tok;
            probe_reg.found <= probe_in.tok && (probe_in.found || match);
            if (probe_in.tok)
            begin
                shift_reg <= probe_in.found || match;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit.load && (count == SLOT))
        begin
            key_reg <= search_key;
        end
        else if (commit.shift && shift_reg)
        begin
            key_reg <= key_right;
        end
    end

    assign probe_out = probe_reg;
    assign key_out   = key_reg;

endmodule

// File: design/ustbl_ctrl.sv
// ----------------------------------------------------------------------------
// ustbl_ctrl
// Request sequencer: latches the request, launches the search token, applies
// the insert or erase and holds the result register.
// ----------------------------------------------------------------------------
module ustbl_ctrl
    import ustbl_pkg::*;
#(
    parameter int unsigned SET_DEPTH = SET_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [OP_W-1:0]                    opcode,
    input  logic signed [KEY_W-1:0]            key,
    output logic signed [KEY_W-1:0]            search_key,
    output ustbl_probe_t                       probe_head,
    input  ustbl_probe_t                       probe_tail,
    output ustbl_commit_t                      commit,
    output logic [$clog2(SET_DEPTH+1)-1:0]     count,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               was_present,
    output logic                               changed,
    output logic                               full_refused,
    output logic [$clog2(SET_DEPTH+1)-1:0]     entry_count
);

    localparam int unsigned CW = $clog2(SET_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(SET_DEPTH);

    ustbl_state_t            state_reg, state_next;
    logic [OP_W-1:0]         op_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic                    head_tok_reg, head_tok_next;
    logic                    present_reg, present_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    was_present_reg, was_present_next;
    logic                    changed_reg, changed_next;
    logic                    refused_reg, refused_next;
    logic [CW-1:0]           entry_count_reg, entry_count_next;
    logic                    accept;

    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_tok_reg  <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_tok_reg  <= head_tok_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            key_reg <= key;
        end
        present_reg     <= present_next;
        was_present_reg <= was_present_next;
        changed_reg     <= changed_next;
        refused_reg     <= refused_next;
        entry_count_reg <= entry_count_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        head_tok_next    = 1'b0;
        present_next     = present_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg && out_stall;
        was_present_next = was_present_reg;
        changed_next     = changed_reg;
        refused_next     = refused_reg;
        entry_count_next = entry_count_reg;
        commit           = '0;
        in_stall         = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    head_tok_next = 1'b1;
                    state_next    = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (probe_tail.tok)
                begin
                    present_next = probe_tail.found;
                    state_next   = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                // wait for the result register to drain
                if (!out_valid_reg || !out_stall)
                begin
                    was_present_next = present_reg;
                    changed_next     = 1'b0;
                    refused_next     = 1'b0;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if (!present_reg)
                            begin
                                if (count_reg == FULL)
                                begin
                                    refused_next = 1'b1;
                                end
                                else
                                begin
                                    commit.load  = 1'b1;
                                    count_next   = count_reg + CW'(1);
                                    changed_next = 1'b1;
                                end
                            end
                        end
                        OP_ERASE:
                        begin
                            if (present_reg)
                            begin
                                commit.shift = 1'b1;
                                count_next   = count_reg - CW'(1);
                                changed_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    entry_count_next = count_next;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign search_key      = key_reg;
    assign probe_head.tok  = head_tok_reg;
    assign probe_head.found = 1'b0;
    assign count           = count_reg;
    assign out_valid       = out_valid_reg;
    assign was_present     = was_present_reg;
    assign changed         = changed_reg;
    assign full_refused    = refused_reg;
    assign entry_count     = entry_count_reg;

endmodule

// File: design/unordered_integer_set_table.sv
// The search token walks the cell chain one slot per cycle, then the commit
// state applies the write once the result register can take it; a new request
// is not taken until the write is committed. A pending result may sit in the
// output register while the next request is taken. Reset clears the stored
// entry count and all control; keys need no reset.
// ----------------------------------------------------------------------------
// unordered_integer_set_table
// Set of distinct signed keys kept in a chain of cells with insert, erase
// and lookup requests.
// ----------------------------------------------------------------------------
module unordered_integer_set_table
    import ustbl_pkg::*;
#(
    parameter int unsigned SET_DEPTH = SET_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [OP_W-1:0]                    opcode,
    input  logic signed [KEY_W-1:0]            key,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               was_present,
    output logic                               changed,
    output logic                               full_refused,
    output logic [$clog2(SET_DEPTH+1)-1:0]     entry_count
);

    localparam int unsigned CW = $clog2(SET_DEPTH + 1);

    logic signed [KEY_W-1:0] search_key;
    ustbl_probe_t            probe_chain [SET_DEPTH+1];
    logic signed [KEY_W-1:0] key_chain [SET_DEPTH];
    ustbl_commit_t           commit;
    logic [CW-1:0]           count;

    ustbl_ctrl #(
        .SET_DEPTH (SET_DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .key          (key),
        .search_key   (search_key),
        .probe_head   (probe_chain[0]),
        .probe_tail   (probe_chain[SET_DEPTH]),
        .commit       (commit),
        .count        (count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .was_present  (was_present),
        .changed      (changed),
        .full_refused (full_refused),
        .entry_count  (entry_count)
    );

    for (genvar i = 0; i < SET_DEPTH; i++)
    begin : g_cell
        logic signed [KEY_W-1:0] right_key;

        if (i == SET_DEPTH - 1)
        begin : g_last
            assign right_key = key_chain[i];
        end
        else
        begin : g_mid
            assign right_key = key_chain[i+1];
        end

        ustbl_cell #(
            .SET_DEPTH (SET_DEPTH),
            .IDX       (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .probe_in   (probe_chain[i]),
            .probe_out  (probe_chain[i+1]),
            .search_key (search_key),
            .count      (count),
            .commit     (commit),
            .key_right  (right_key),
            .key_out    (key_chain[i])
        );
    end

    // entry count never runs past the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(SET_DEPTH))
        else $error("entry count beyond depth");

    // a request blocks the input until its result is committed
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second request taken while searching");

    // a refusal only happens on a full store and never with a change
    a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && full_refused) |-> (!changed && entry_count == CW'(SET_DEPTH)))
        else $error("refusal without full store");

    // a change (an insert of an absent key or an erase of a present one) is never flagged with a refusal
    a_insert_new: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && changed) |-> !full_refused)
        else $error("change flagged with refusal");

endmodule
